/* hw/rtl/rotated_sorted_array_search_macros.svh */
// ----------------------------------------------------------------------------
// Assertion macros for the rotated sorted array search block
// Shorthand for clocked implication checks, disabled while in reset.
// ----------------------------------------------------------------------------
`ifndef ROTATED_SORTED_ARRAY_SEARCH_MACROS_SVH
`define ROTATED_SORTED_ARRAY_SEARCH_MACROS_SVH

// same-cycle implication
`define RSAS_ASSERT_SAME(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define RSAS_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* hw/rtl/rsas_pkg.sv */
// ----------------------------------------------------------------------------
// rsas_pkg
// Shared constants and types for the rotated sorted array search block.
// ----------------------------------------------------------------------------
package rsas_pkg;

    localparam int STORE_DEPTH = 1024;
    localparam int VALUE_W     = 32;
    localparam int IDX_W       = $clog2(STORE_DEPTH);
    localparam int CNT_W       = IDX_W + 1;

    localparam logic [1:0] MODE_APPEND = 2'd0;
    localparam logic [1:0] MODE_SEARCH = 2'd1;
    localparam logic [1:0] MODE_CLEAR  = 2'd2;

    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_FULL  = 2'd1;
    localparam logic [1:0] ST_EMPTY = 2'd2;

    localparam logic [CNT_W-1:0] CNT_ONE   = {{IDX_W{1'b0}}, 1'b1};
    localparam logic [CNT_W-1:0] CNT_DEPTH = CNT_W'(STORE_DEPTH);

    typedef struct packed {
        logic [1:0]       status;
        logic [IDX_W-1:0] found_index;
        logic             found;
    } res_t;

    typedef struct packed {
        logic               en;
        logic [IDX_W-1:0]   addr;
        logic [VALUE_W-1:0] data;
    } mem_wr_t;

endpackage

/* hw/rtl/rsas_store.sv */
// ----------------------------------------------------------------------------
// rsas_store
// Element store: one write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module rsas_store
(
    input  logic                        clk,
    input  rsas_pkg::mem_wr_t           wr,
    input  logic [rsas_pkg::IDX_W-1:0]  rd_addr,
    output logic [rsas_pkg::VALUE_W-1:0] rd_data
);

    logic [rsas_pkg::VALUE_W-1:0] mem [rsas_pkg::STORE_DEPTH];
    logic [rsas_pkg::VALUE_W-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr.en)
        begin
            mem[wr.addr] <= wr.data;
        end
        rd_data_reg <= mem[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

/* hw/rtl/rsas_seq.sv */
// ----------------------------------------------------------------------------
// rsas_seq
// Sequencer for append, clear and search; a search runs a pivot search, then
// one or two binary searches, one store read per step.
// ----------------------------------------------------------------------------
module rsas_seq
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    input  logic [1:0]                    in_mode,
    input  logic [rsas_pkg::VALUE_W-1:0]  in_value,
    output logic                          in_ready,
    input  logic                          slot_free,
    output logic                          res_valid,
    output rsas_pkg::res_t                res,
    output rsas_pkg::mem_wr_t             mem_wr,
    output logic [rsas_pkg::IDX_W-1:0]    rd_addr,
    input  logic [rsas_pkg::VALUE_W-1:0]  rd_data
);

    localparam int CNT_W = rsas_pkg::CNT_W;
    localparam int IDX_W = rsas_pkg::IDX_W;
    localparam int VW    = rsas_pkg::VALUE_W;

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_PHI  = 3'd1;
    localparam logic [2:0] S_PCMP = 3'd2;
    localparam logic [2:0] S_BCMP = 3'd3;
    localparam logic [2:0] S_DONE = 3'd4;

    logic [2:0]       state_reg, state_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic [CNT_W-1:0] lo_reg, lo_next;
    logic [CNT_W-1:0] hi_reg, hi_next;
    logic [CNT_W-1:0] pivot_reg, pivot_next;
    logic             phase_reg, phase_next;
    logic [IDX_W-1:0] mid_reg, mid_next;
    logic [VW-1:0]    key_reg, key_next;
    logic [VW-1:0]    hi_val_reg, hi_val_next;
    rsas_pkg::res_t   res_reg, res_next;

    logic [CNT_W:0]   sum;
    logic [CNT_W-1:0] mid_inc;

    assign in_ready = (state_reg == S_IDLE);
    assign mid_inc  = {1'b0, mid_reg} + rsas_pkg::CNT_ONE;

    always_comb
    begin
        state_next  = state_reg;
        count_next  = count_reg;
        lo_next     = lo_reg;
        hi_next     = hi_reg;
        pivot_next  = pivot_reg;
        phase_next  = phase_reg;
        key_next    = key_reg;
        hi_val_next = hi_val_reg;
        res_next    = res_reg;
        res_valid   = 1'b0;
        mem_wr.en   = 1'b0;
        mem_wr.addr = count_reg[IDX_W-1:0];
        mem_wr.data = in_value;

        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    case (in_mode)
                        rsas_pkg::MODE_APPEND:
                        begin
                            res_next.found       = 1'b0;
                            res_next.found_index = '0;
                            if (count_reg < rsas_pkg::CNT_DEPTH)
                            begin
                                mem_wr.en       = 1'b1;
                                count_next      = count_reg + rsas_pkg::CNT_ONE;
                                res_next.status = rsas_pkg::ST_OK;
                            end
                            else
                            begin
                                res_next.status = rsas_pkg::ST_FULL;
                            end
                            state_next = S_DONE;
                        end
                        rsas_pkg::MODE_SEARCH:
                        begin
                            res_next.found       = 1'b0;
                            res_next.found_index = '0;
                            if (count_reg == '0)
                            begin
                                res_next.status = rsas_pkg::ST_EMPTY;
                                state_next      = S_DONE;
                            end
                            else
                            begin
                                res_next.status = rsas_pkg::ST_OK;
                                key_next        = in_value;
                                lo_next         = '0;
                                hi_next         = count_reg - rsas_pkg::CNT_ONE;
                                state_next      = S_PHI;
                            end
                        end
                        rsas_pkg::MODE_CLEAR:
                        begin
                            count_next = '0;
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end
            S_PHI:
            begin
                hi_val_next = rd_data;
                if (hi_reg == '0)
                begin
                    pivot_next = '0;
                    lo_next    = '0;
                    hi_next    = count_reg;
                    phase_next = 1'b1;
                    state_next = S_BCMP;
                end
                else
                begin
                    state_next = S_PCMP;
                end
            end
            S_PCMP:
            begin
                if ($signed(rd_data) > $signed(hi_val_reg))
                begin
                    lo_next = mid_inc;
                end
                else
                begin
                    hi_next     = {1'b0, mid_reg};
                    hi_val_next = rd_data;
                end
                if (!(lo_next < hi_next))
                begin
                    pivot_next = lo_next;
                    if (lo_next == '0)
                    begin
                        hi_next    = count_reg;
                        phase_next = 1'b1;
                    end
                    else
                    begin
                        hi_next    = lo_next;
                        lo_next    = '0;
                        phase_next = 1'b0;
                    end
                    state_next = S_BCMP;
                end
            end
            S_BCMP:
            begin
                if (rd_data == key_reg)
                begin
                    res_next.found       = 1'b1;
                    res_next.found_index = mid_reg;
                    state_next           = S_DONE;
                end
                else
                begin
                    if ($signed(key_reg) < $signed(rd_data))
                    begin
                        hi_next = {1'b0, mid_reg};
                    end
                    else
                    begin
                        lo_next = mid_inc;
                    end
                    if (!(lo_next < hi_next))
                    begin
                        if (!phase_reg)
                        begin
                            phase_next = 1'b1;
                            lo_next    = pivot_reg;
                            hi_next    = count_reg;
                        end
                        else
                        begin
                            state_next = S_DONE;
                        end
                    end
                end
            end
            S_DONE:
            begin
                if (slot_free)
                begin
                    res_valid  = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        // pivot phase: hi inclusive; search phase: hi exclusive
        sum = {1'b0, lo_next} + {1'b0, hi_next}
              - ((state_next == S_BCMP) ? {{CNT_W{1'b0}}, 1'b1} : {(CNT_W+1){1'b0}});
        mid_next = sum[IDX_W:1];
        rd_addr  = (state_next == S_PHI) ? hi_next[IDX_W-1:0] : mid_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            count_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        lo_reg     <= lo_next;
        hi_reg     <= hi_next;
        pivot_reg  <= pivot_next;
        phase_reg  <= phase_next;
        mid_reg    <= mid_next;
        key_reg    <= key_next;
        hi_val_reg <= hi_val_next;
        res_reg    <= res_next;
    end

    assign res = res_reg;

endmodule

/* hw/rtl/rotated_sorted_array_search.sv */
// Append: result word goes to the output register after the sequencer; clear: no result.
// Search: a pivot search, then the compare steps of one or both binary searches;
// one step per cycle, one store read per step.
// One item in flight; next word accepted from the cycle after the result leaves the sequencer.
// Reset (rst_n, async, active low) empties the store and clears control state;
// store contents are not cleared.
// ----------------------------------------------------------------------------
// rotated_sorted_array_search
// Top level: stream ports, result word register, sequencer and store.
// ----------------------------------------------------------------------------
module rotated_sorted_array_search
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [31:0] s_axis_tdata,   // [31:0] item_value
    input  logic [1:0]  s_axis_tuser,   // [1:0] mode
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [15:0] m_axis_tdata    // [0] found, [10:1] found_index, [12:11] status
);

    logic                           slot_free;
    logic                           res_valid;
    rsas_pkg::res_t                 res;
    rsas_pkg::mem_wr_t              mem_wr;
    logic [rsas_pkg::IDX_W-1:0]     rd_addr;
    logic [rsas_pkg::VALUE_W-1:0]   rd_data;
    logic                           out_valid_reg;
    rsas_pkg::res_t                 out_data_reg;

    assign slot_free = !out_valid_reg || m_axis_tready;

    rsas_seq u_seq
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_axis_tvalid),
        .in_mode   (s_axis_tuser),
        .in_value  (s_axis_tdata),
        .in_ready  (s_axis_tready),
        .slot_free (slot_free),
        .res_valid (res_valid),
        .res       (res),
        .mem_wr    (mem_wr),
        .rd_addr   (rd_addr),
        .rd_data   (rd_data)
    );

    rsas_store u_store
    (
        .clk     (clk),
        .wr      (mem_wr),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (res_valid)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (m_axis_tready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (res_valid)
        begin
            out_data_reg <= res;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {3'b000, out_data_reg};

endmodule

/* hw/rtl/rsas_chk.sv */
// ----------------------------------------------------------------------------
// rsas_chk
// Port-level checks for the rotated sorted array search block.
// ----------------------------------------------------------------------------
`include "rotated_sorted_array_search_macros.svh"

module rsas_chk
(
    input logic        clk,
    input logic        rst_n,
    input logic        s_axis_tvalid,
    input logic        s_axis_tready,
    input logic [1:0]  s_axis_tuser,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [15:0] m_axis_tdata
);

    logic in_hs;
    logic in_work;
    logic in_clear;

    assign in_hs    = s_axis_tvalid && s_axis_tready;
    assign in_work  = in_hs && (s_axis_tuser == rsas_pkg::MODE_APPEND ||
                                s_axis_tuser == rsas_pkg::MODE_SEARCH);
    assign in_clear = in_hs && (s_axis_tuser == rsas_pkg::MODE_CLEAR);

    `RSAS_ASSERT_NEXT(a_out_hold, clk, rst_n, m_axis_tvalid && !m_axis_tready,
        m_axis_tvalid && $stable(m_axis_tdata), "result word changed while stalled")
    `RSAS_ASSERT_NEXT(a_busy_after_work, clk, rst_n, in_work,
        !s_axis_tready, "ready after an append or search word")
    `RSAS_ASSERT_NEXT(a_clear_idle, clk, rst_n, in_clear,
        s_axis_tready, "not ready after a clear word")
    `RSAS_ASSERT_SAME(a_status_code, clk, rst_n, m_axis_tvalid,
        m_axis_tdata[12:11] != 2'd3 && m_axis_tdata[15:13] == 3'd0,
        "bad status code or padding")
    `RSAS_ASSERT_SAME(a_miss_index, clk, rst_n, m_axis_tvalid && !m_axis_tdata[0],
        m_axis_tdata[10:1] == '0, "nonzero index without a match")

endmodule

bind rotated_sorted_array_search rsas_chk u_rsas_chk
(
    .clk           (clk),
    .rst_n         (rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);

/* sim/rotated_sorted_array_search_tb.sv */
// ----------------------------------------------------------------------------
// rotated_sorted_array_search_tb
// Self-checking bench for the rotated sorted array search block. Words are
// streamed in with random bursts and gaps while the result side stalls on its
// own pattern. A local model of the store predicts every result word, and
// each received word is compared field by field against the oldest
// prediction. Covers empty and full stores, clears, ignored modes, rotated
// and unsorted contents.
// ----------------------------------------------------------------------------
module rotated_sorted_array_search_tb;

    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [1:0] MODE_UNUSED  = 2'd3;
    localparam int         CYCLE_LIMIT  = 1000000;
    localparam int         RANDOM_ITEMS = 750;
    localparam int         DRAIN_CYCLES = 80;

    logic        clk;
    logic        rst_n;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [31:0] s_axis_tdata;   // [31:0] item_value
    logic [1:0]  s_axis_tuser;   // [1:0] mode
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [15:0] m_axis_tdata;   // [0] found, [10:1] found_index, [12:11] status

    rotated_sorted_array_search DUT
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    // local copy of the store
    logic signed [rsas_pkg::VALUE_W-1:0] model_store [0:rsas_pkg::STORE_DEPTH-1];
    int                                  model_count;
    rsas_pkg::res_t                      pending_results [$];

    int error_count = 0;
    int cycle_count = 0;
    int words_sent;
    int burst_left;
    int stall_pct = 0;
    rsas_pkg::res_t got_res;
    rsas_pkg::res_t want_res;

    logic signed [rsas_pkg::VALUE_W-1:0] seq_vals [0:rsas_pkg::STORE_DEPTH-1];
    int                                  seq_len;

    initial clk = 1'b0;
    always #10 clk = ~clk;

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        error_count++;
        $display("ERROR @%0t: %s: got 0x%0h, expected 0x%0h", $time, what, got, want);
    endtask

    function automatic int locate_pivot();
        int lo;
        int hi;
        int mid;
        lo = 0;
        hi = model_count - 1;
        while (lo < hi)
        begin
            mid = lo + (hi - lo) / 2;
            if (model_store[mid] > model_store[hi])
                lo = mid + 1;
            else
                hi = mid;
        end
        return lo;
    endfunction

    function automatic int scan_range(input int lo_in, input int hi_in,
                                      input logic signed [rsas_pkg::VALUE_W-1:0] target);
        int lo;
        int hi;
        int mid;
        lo = lo_in;
        hi = hi_in;
        while (lo <= hi)
        begin
            mid = lo + (hi - lo) / 2;
            if (model_store[mid] == target)
                return mid;
            if (target < model_store[mid])
                hi = mid - 1;
            else
                lo = mid + 1;
        end
        return -1;
    endfunction

    task automatic predict_response(input logic [1:0] mode,
                                    input logic signed [rsas_pkg::VALUE_W-1:0] value);
        rsas_pkg::res_t r;
        int   pivot;
        int   pos;
        logic [31:0] pos_bits;
        r = '0;
        case (mode)
            rsas_pkg::MODE_APPEND:
            begin
                if (model_count < rsas_pkg::STORE_DEPTH)
                begin
                    model_store[model_count] = value;
                    model_count++;
                    r.status = rsas_pkg::ST_OK;
                end
                else
                    r.status = rsas_pkg::ST_FULL;
                pending_results.push_back(r);
            end
            rsas_pkg::MODE_SEARCH:
            begin
                if (model_count == 0)
                    r.status = rsas_pkg::ST_EMPTY;
                else
                begin
                    r.status = rsas_pkg::ST_OK;
                    pivot = locate_pivot();
                    pos = scan_range(0, pivot - 1, value);
                    if (pos < 0)
                        pos = scan_range(pivot, model_count - 1, value);
                    if (pos >= 0)
                    begin
                        pos_bits      = pos;
                        r.found       = 1'b1;
                        r.found_index = pos_bits[rsas_pkg::IDX_W-1:0];
                    end
                end
                pending_results.push_back(r);
            end
            rsas_pkg::MODE_CLEAR:
                model_count = 0;
            default: ;
        endcase
    endtask

    // called just after a rising edge; returns just after the accepting edge
    task automatic send_word(input logic [1:0] mode, input logic [31:0] value);
        int gap;
        if (burst_left == 0)
        begin
            burst_left = $urandom_range(1, 16);
            gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 12);
            if (gap > 0)
            begin
                s_axis_tvalid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
        burst_left--;
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= value;
        s_axis_tuser  <= mode;
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
        predict_response(mode, value);
        if (mode != MODE_UNUSED)
            words_sent++;
    endtask

    // sorted values (sometimes with repeats) into seq_vals[0..n-1]
    task automatic build_sorted(input int n);
        logic signed [rsas_pkg::VALUE_W-1:0] v;
        int i;
        int j;
        bit narrow;
        narrow = ($urandom_range(0, 3) == 0);
        for (i = 0; i < n; i++)
        begin
            v = narrow ? $signed(32'($urandom_range(0, 7)) - 32'd4) : $urandom;
            j = i;
            while (j > 0 && seq_vals[j-1] > v)
            begin
                seq_vals[j] = seq_vals[j-1];
                j--;
            end
            seq_vals[j] = v;
        end
        seq_len = n;
    endtask

    task automatic test_directed();
        send_word(rsas_pkg::MODE_SEARCH, 32'd0);
        send_word(MODE_UNUSED, 32'h7fff_ffff);
        send_word(rsas_pkg::MODE_APPEND, 32'd3);
        send_word(rsas_pkg::MODE_APPEND, 32'd1);
        send_word(rsas_pkg::MODE_SEARCH, 32'd1);
        send_word(rsas_pkg::MODE_SEARCH, 32'd3);
        send_word(rsas_pkg::MODE_SEARCH, 32'd2);
        send_word(rsas_pkg::MODE_CLEAR,  32'hffff_ffff);
        send_word(rsas_pkg::MODE_APPEND, 32'h8000_0000);
        send_word(rsas_pkg::MODE_APPEND, 32'hffff_ffff);
        send_word(rsas_pkg::MODE_APPEND, 32'd0);
        send_word(rsas_pkg::MODE_APPEND, 32'h7fff_ffff);
        send_word(rsas_pkg::MODE_SEARCH, 32'h8000_0000);
        send_word(rsas_pkg::MODE_SEARCH, 32'h7fff_ffff);
        send_word(rsas_pkg::MODE_SEARCH, 32'd0);
        send_word(rsas_pkg::MODE_SEARCH, 32'd1);
        send_word(rsas_pkg::MODE_CLEAR,  32'd0);
        send_word(rsas_pkg::MODE_APPEND, 32'd5);
        send_word(rsas_pkg::MODE_APPEND, 32'd6);
        send_word(rsas_pkg::MODE_APPEND, 32'd7);
        send_word(rsas_pkg::MODE_APPEND, 32'd1);
        send_word(rsas_pkg::MODE_APPEND, 32'd2);
        send_word(rsas_pkg::MODE_SEARCH, 32'd7);
        send_word(rsas_pkg::MODE_SEARCH, 32'd1);
        send_word(rsas_pkg::MODE_SEARCH, 32'd4);
    endtask

    task automatic test_full_store();
        int i;
        logic [31:0] v;
        send_word(rsas_pkg::MODE_CLEAR, 32'd0);
        for (i = 0; i < rsas_pkg::STORE_DEPTH; i++)
        begin
            v = 32'h8000_0001 + 32'((i + 324) % rsas_pkg::STORE_DEPTH) * 32'h0040_0000;
            send_word(rsas_pkg::MODE_APPEND, v);
        end
        send_word(rsas_pkg::MODE_APPEND, 32'h1234_5678);
        send_word(rsas_pkg::MODE_APPEND, 32'h8000_0000);
        send_word(rsas_pkg::MODE_SEARCH, model_store[rsas_pkg::STORE_DEPTH-1]);
        send_word(rsas_pkg::MODE_SEARCH, model_store[0]);
        send_word(rsas_pkg::MODE_SEARCH, model_store[699]);
        send_word(rsas_pkg::MODE_SEARCH, model_store[700]);
        send_word(rsas_pkg::MODE_SEARCH, model_store[512]);
        send_word(rsas_pkg::MODE_SEARCH, 32'h8000_0000);
        send_word(rsas_pkg::MODE_SEARCH, 32'h7fff_ffff);
        send_word(rsas_pkg::MODE_CLEAR, 32'd0);
    endtask

    task automatic test_random();
        int n;
        int k;
        int i;
        int q;
        int pick;
        logic [31:0] target;
        logic [1:0]  mode;
        while (words_sent < RANDOM_ITEMS)
        begin
            if ($urandom_range(0, 9) < 7)
            begin
                n = ($urandom_range(0, 19) == 0) ? $urandom_range(100, 400)
                                                 : $urandom_range(1, 24);
                build_sorted(n);
                k = $urandom_range(0, n - 1);
                if ($urandom_range(0, 7) != 0)
                    send_word(rsas_pkg::MODE_CLEAR, $urandom);
                for (i = 0; i < n; i++)
                    send_word(rsas_pkg::MODE_APPEND, seq_vals[(i + k) % n]);
                q = $urandom_range(2, 8);
                for (i = 0; i < q; i++)
                begin
                    pick = $urandom_range(0, 9);
                    target = seq_vals[$urandom_range(0, n - 1)];
                    if (pick >= 8)
                        target = $urandom;
                    else if (pick >= 6)
                        target = target + (pick[0] ? 32'd1 : 32'hffff_ffff);
                    send_word(rsas_pkg::MODE_SEARCH, target);
                end
            end
            else
            begin
                q = $urandom_range(1, 6);
                for (i = 0; i < q; i++)
                begin
                    mode = 2'($urandom_range(0, 3));
                    target = $urandom;
                    if (model_count > 0 && $urandom_range(0, 1) == 0)
                        target = model_store[$urandom_range(0, model_count - 1)];
                    send_word(mode, target);
                end
            end
        end
    endtask

    // result side: check, then pick tready for the next edge
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            if (pending_results.size() == 0)
                report_mismatch("unexpected result word", 32'(m_axis_tdata), 32'd0);
            else
            begin
                want_res = pending_results.pop_front();
                got_res  = rsas_pkg::res_t'(m_axis_tdata[12:0]);
                if (got_res.found != want_res.found)
                    report_mismatch("found", 32'(got_res.found), 32'(want_res.found));
                if (got_res.found_index != want_res.found_index)
                    report_mismatch("found_index", 32'(got_res.found_index),
                                    32'(want_res.found_index));
                if (got_res.status != want_res.status)
                    report_mismatch("status", 32'(got_res.status), 32'(want_res.status));
                if (m_axis_tdata[15:13] != 3'd0)
                    report_mismatch("pad bits", 32'(m_axis_tdata[15:13]), 32'd0);
            end
        end
        if (cycle_count % 200 == 0)
        begin
            case ($urandom_range(0, 4))
                0, 1:    stall_pct = 0;
                2:       stall_pct = 25;
                3:       stall_pct = 50;
                default: stall_pct = 90;
            endcase
        end
        m_axis_tready <= rst_n && ($urandom_range(0, 99) >= stall_pct);
    end

    initial
    begin
        rst_n         = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        s_axis_tuser  = '0;
        words_sent    = 0;
        burst_left    = 0;
        model_count   = 0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed();
        test_full_store();
        words_sent = 0;
        test_random();
        s_axis_tvalid <= 1'b0;

        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (error_count == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule

/* sim.f */
+incdir+hw/rtl
hw/rtl/rsas_pkg.sv
hw/rtl/rsas_store.sv
hw/rtl/rsas_seq.sv
hw/rtl/rotated_sorted_array_search.sv
hw/rtl/rsas_chk.sv
sim/rotated_sorted_array_search_tb.sv
